@@ rtl/srsw_pkg.sv @@
// shared types, constants and helper functions of the selective-repeat sender window
// no dependencies: compile first
package srsw_pkg;

   // window geometry
   localparam int WINDOW_SLOTS = 4;
   localparam int SEQ_BITS     = 3;
   localparam int SLOT_BITS    = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

   // operation codes
   localparam logic [1:0] OP_SEND    = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   typedef logic [SEQ_BITS-1:0]  seq_type;
   typedef logic [SLOT_BITS-1:0] slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SLIDE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic slide;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slide_more;
      logic out_free;
   } sts_type;

   // one result item, less the window base
   typedef struct packed {
      logic     accepted;
      logic     transmit;
      seq_type  packet_seq;
      slot_type packet_slot;
      logic     timer_start;
      logic     timer_stop;
   } res_type;

   // window slot that carries a sequence number
   function automatic slot_type seq_slot(seq_type seq);
      return SLOT_BITS'(seq % WINDOW_SLOTS);
   endfunction

   // true when 'to' lies less than a window ahead of 'from', modulo the sequence space
   function automatic logic in_window(seq_type from, seq_type to);
      seq_type gap;
      gap = to - from;
      return int'(gap) < WINDOW_SLOTS;
   endfunction

endpackage

@@ rtl/srsw_req_if.sv @@
// request channel of the sender window: valid/ready handshake and one input item
// depends on srsw_pkg
interface srsw_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   srsw_pkg::seq_type  ack_number;
   logic               ack_valid;
   srsw_pkg::slot_type timeout_slot;

   modport source (output valid, operation, ack_number, ack_valid, timeout_slot,
                   input ready);
   modport sink (input valid, operation, ack_number, ack_valid, timeout_slot,
                 output ready);
endinterface

@@ rtl/srsw_rsp_if.sv @@
// response channel of the sender window: valid/ready handshake and one result item
// depends on srsw_pkg
interface srsw_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               transmit;
   srsw_pkg::seq_type  packet_seq;
   srsw_pkg::slot_type packet_slot;
   logic               timer_start;
   logic               timer_stop;
   srsw_pkg::seq_type  window_base;

   modport source (output valid, accepted, transmit, packet_seq, packet_slot,
                   timer_start, timer_stop, window_base,
                   input ready);
   modport sink (input valid, accepted, transmit, packet_seq, packet_slot,
                 timer_start, timer_stop, window_base,
                 output ready);
endinterface

@@ rtl/selective_repeat_sender_window_core.sv @@
// top level of the selective-repeat sender window: controller, datapath, channel ports
// depends on srsw_pkg, srsw_req_if, srsw_rsp_if, srsw_ctrl, srsw_dpath
//
// window bookkeeping for a selective-repeat arq sender. each request item is one
// operation: send (take the next sequence number if the window has room, start its
// slot timer), ack (mark a valid in-window acknowledgement, stop its timer, slide the
// base over consecutive acknowledged slots) or timeout (resend the number stored in a
// slot and restart its timer). every item gives exactly one response item carrying the
// window base after the step. one item is handled at a time: capture, execute, a slide walk
// of one step per slid slot plus one check, then load of the output register, which waits
// while the last response is not taken; an ack slides the base over up to the window size.
// the output register lets a new item be taken while the last response still waits.
// the slot sequence table is not cleared at reset; a timeout on a slot never sent
// through returns an unspecified number
module selective_repeat_sender_window_core (
   input  logic       clock,
   input  logic       reset,
   srsw_req_if.sink   req_ch,
   srsw_rsp_if.source rsp_ch
);

   srsw_pkg::cmd_type cmd;
   srsw_pkg::sts_type sts;
   srsw_pkg::res_type rsp_res;
   logic              req_ready;

   // sequencing: idle, execute, slide walk, emit
   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // window state, slot table and output register
   srsw_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_ch.operation),
      .req_ack_number   (req_ch.ack_number),
      .req_ack_valid    (req_ch.ack_valid),
      .req_timeout_slot (req_ch.timeout_slot),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_res          (rsp_res),
      .rsp_window_base  (rsp_ch.window_base)
   );

   assign req_ch.ready = req_ready;

   // unpack the result item onto the response channel
   assign rsp_ch.accepted    = rsp_res.accepted;
   assign rsp_ch.transmit    = rsp_res.transmit;
   assign rsp_ch.packet_seq  = rsp_res.packet_seq;
   assign rsp_ch.packet_slot = rsp_res.packet_slot;
   assign rsp_ch.timer_start = rsp_res.timer_start;
   assign rsp_ch.timer_stop  = rsp_res.timer_stop;

endmodule

@@ rtl/srsw_ctrl.sv @@
// sequencing state machine of the sender window
// depends on srsw_pkg; drives srsw_dpath through cmd_type, reads sts_type
module srsw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srsw_pkg::sts_type sts,
   output srsw_pkg::cmd_type cmd
);

   srsw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srsw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            if (req_valid) state_in = srsw_pkg::ST_EXEC;
         end
         srsw_pkg::ST_EXEC: begin
            state_in = srsw_pkg::ST_SLIDE;
         end
         srsw_pkg::ST_SLIDE: begin
            if (!sts.slide_more) state_in = srsw_pkg::ST_EMIT;
         end
         srsw_pkg::ST_EMIT: begin
            if (sts.out_free) state_in = srsw_pkg::ST_IDLE;
         end
         default: begin
            state_in = srsw_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         srsw_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         srsw_pkg::ST_SLIDE: begin
            cmd.slide = sts.slide_more;
         end
         srsw_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/srsw_dpath.sv @@
// window state, slot table, result and output registers of the sender window
// depends on srsw_pkg; controlled by srsw_ctrl
module srsw_dpath (
   input  logic               clock,
   input  logic               reset,
   input  srsw_pkg::cmd_type  cmd,
   output srsw_pkg::sts_type  sts,
   input  logic [1:0]         req_operation,
   input  srsw_pkg::seq_type  req_ack_number,
   input  logic               req_ack_valid,
   input  srsw_pkg::slot_type req_timeout_slot,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output srsw_pkg::res_type  rsp_res,
   output srsw_pkg::seq_type  rsp_window_base
);

   // captured item
   logic [1:0]         op_ff;
   srsw_pkg::seq_type  ack_ff;
   logic               ack_valid_ff;
   srsw_pkg::slot_type tslot_ff;

   // window state
   srsw_pkg::seq_type                      base_ff, base_in;
   srsw_pkg::seq_type                      next_ff, next_in;
   logic [srsw_pkg::WINDOW_SLOTS-1:0]      marks_ff, marks_in;
   srsw_pkg::seq_type                      slot_seq_ff [srsw_pkg::WINDOW_SLOTS];
   logic                                   slot_wr_en;
   srsw_pkg::slot_type                     slot_wr_idx;

   // working result and slide enable
   srsw_pkg::res_type res_ff, res_in;
   logic              slide_en_ff, slide_en_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   srsw_pkg::res_type out_res_ff;
   srsw_pkg::seq_type out_base_ff;

   srsw_pkg::slot_type ack_slot;
   srsw_pkg::slot_type next_slot;
   srsw_pkg::slot_type base_slot;
   srsw_pkg::seq_type  occupancy;

   assign ack_slot  = srsw_pkg::seq_slot(ack_ff);
   assign next_slot = srsw_pkg::seq_slot(next_ff);
   assign base_slot = srsw_pkg::seq_slot(base_ff);
   assign occupancy = next_ff - base_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_operation;
         ack_ff       <= req_ack_number;
         ack_valid_ff <= req_ack_valid;
         tslot_ff     <= req_timeout_slot;
      end
   end

   always_comb begin
      base_in     = base_ff;
      next_in     = next_ff;
      marks_in    = marks_ff;
      res_in      = res_ff;
      slide_en_in = slide_en_ff;
      slot_wr_en  = 1'b0;
      slot_wr_idx = next_slot;
      if (cmd.execute) begin
         res_in      = '0;
         slide_en_in = 1'b0;
         case (op_ff)
            srsw_pkg::OP_SEND: begin
               if (srsw_pkg::in_window(base_ff, next_ff)) begin
                  slot_wr_en            = 1'b1;
                  marks_in[next_slot]   = 1'b0;
                  res_in.accepted       = 1'b1;
                  res_in.transmit       = 1'b1;
                  res_in.packet_seq     = next_ff;
                  res_in.packet_slot    = next_slot;
                  res_in.timer_start    = 1'b1;
                  next_in               = next_ff + 1'b1;
               end
            end
            srsw_pkg::OP_ACK: begin
               if (ack_valid_ff && srsw_pkg::in_window(base_ff, ack_ff) &&
                   !marks_ff[ack_slot]) begin
                  marks_in[ack_slot] = 1'b1;
                  res_in.packet_slot = ack_slot;
                  res_in.timer_stop  = 1'b1;
                  slide_en_in        = 1'b1;
               end
            end
            srsw_pkg::OP_TIMEOUT: begin
               if (int'(tslot_ff) < srsw_pkg::WINDOW_SLOTS) begin
                  res_in.transmit    = 1'b1;
                  res_in.packet_seq  = slot_seq_ff[tslot_ff];
                  res_in.packet_slot = tslot_ff;
                  res_in.timer_start = 1'b1;
               end
            end
            default: begin
               res_in = '0;
            end
         endcase
      end else if (cmd.slide) begin
         // one acknowledged slot leaves the window
         marks_in[base_slot] = 1'b0;
         base_in             = base_ff + 1'b1;
      end
   end

   assign sts.slide_more = slide_en_ff && (base_ff != next_ff) && marks_ff[base_slot];
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (cmd.emit)  out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         marks_ff     <= '0;
         slide_en_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         marks_ff     <= marks_in;
         slide_en_ff  <= slide_en_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (slot_wr_en) slot_seq_ff[slot_wr_idx] <= next_ff;
      if (cmd.emit) begin
         out_res_ff  <= res_ff;
         out_base_ff <= base_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_res         = out_res_ff;
   assign rsp_window_base = out_base_ff;

   // window never holds more packets than it has slots
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      int'(occupancy) <= srsw_pkg::WINDOW_SLOTS)
      else $error("window occupancy exceeds slot count");

   // the base only moves through slide steps
   a_base_moves: assert property (@(posedge clock) disable iff (reset)
      !cmd.slide |=> $stable(base_ff))
      else $error("base moved outside a slide step");

   // a slide step never passes the next sequence number
   a_slide_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.slide |-> (base_ff != next_ff))
      else $error("slide passed next sequence number");

   // a taken send always transmits and starts the timer, never stops it
   a_send_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.accepted |->
         out_res_ff.transmit && out_res_ff.timer_start && !out_res_ff.timer_stop)
      else $error("inconsistent send result");

   // an emit never overwrites a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

@@ dv/tb.sv @@
// self-checking testbench of the selective-repeat sender window core
// depends on srsw_pkg, srsw_req_if, srsw_rsp_if and selective_repeat_sender_window_core
`timescale 1ns / 100ps

module tb;
   import srsw_pkg::*;

   localparam int RANDOM_ITEMS = 625;   // on top of the directed items
   localparam int QUIET_TAIL   = 120;   // last random items run with no idling
   localparam int DRAIN_CYCLES = 16;    // drain margin after the last expected result
   localparam int LIMIT_CYCLES = 200000;

   // one result item as seen on the response channel
   typedef struct packed {
      logic     accepted;
      logic     transmit;
      seq_type  packet_seq;
      slot_type packet_slot;
      logic     timer_start;
      logic     timer_stop;
      seq_type  window_base;
   } step_result_type;

   // window state tracker: predicts one result per request item and checks it
   class window_tracker;
      seq_type         oldest_seq;                // oldest unacknowledged number
      seq_type         send_seq;                  // number the next send takes
      bit              acked [WINDOW_SLOTS];
      seq_type         sent_seq [WINDOW_SLOTS];
      bit              sent_once [WINDOW_SLOTS];  // slot has been sent through
      step_result_type expected_q [$];
      int              errors;
      int              checked;
      int              refused;
      int              slides;
      int              resends;

      function new();
         oldest_seq = '0;
         send_seq   = '0;
         for (int i = 0; i < WINDOW_SLOTS; i++) begin
            acked[i]     = 1'b0;
            sent_seq[i]  = '0;
            sent_once[i] = 1'b0;
         end
         errors  = 0;
         checked = 0;
         refused = 0;
         slides  = 0;
         resends = 0;
      endfunction

      function int seq_gap(seq_type from, seq_type to);
         seq_type d;
         d = to - from;
         return int'(d);
      endfunction

      function slot_type slot_of(seq_type s);
         return slot_type'(int'(s) % WINDOW_SLOTS);
      endfunction

      // work out the result of one accepted request item and queue it
      function void log_request(logic [1:0] op, seq_type ack, logic ack_ok, slot_type tslot);
         step_result_type res;
         slot_type        s;
         seq_type         start_base;
         res = '0;
         case (op)
            OP_SEND: begin
               if (seq_gap(oldest_seq, send_seq) < WINDOW_SLOTS) begin
                  s               = slot_of(send_seq);
                  sent_seq[s]     = send_seq;
                  sent_once[s]    = 1'b1;
                  // a fresh send drops any mark left by an early ack
                  acked[s]        = 1'b0;
                  res.accepted    = 1'b1;
                  res.transmit    = 1'b1;
                  res.packet_seq  = send_seq;
                  res.packet_slot = s;
                  res.timer_start = 1'b1;
                  send_seq        = send_seq + 1'b1;
               end else begin
                  refused++;
               end
            end
            OP_ACK: begin
               if (ack_ok && seq_gap(oldest_seq, ack) < WINDOW_SLOTS) begin
                  s = slot_of(ack);
                  if (!acked[s]) begin
                     acked[s]        = 1'b1;
                     res.packet_slot = s;
                     res.timer_stop  = 1'b1;
                     start_base      = oldest_seq;
                     while (oldest_seq != send_seq && acked[slot_of(oldest_seq)]) begin
                        acked[slot_of(oldest_seq)] = 1'b0;
                        oldest_seq = oldest_seq + 1'b1;
                     end
                     if (oldest_seq != start_base)
                        slides++;
                  end
               end
            end
            OP_TIMEOUT: begin
               if (int'(tslot) < WINDOW_SLOTS) begin
                  res.transmit    = 1'b1;
                  res.packet_seq  = sent_seq[tslot];
                  res.packet_slot = tslot;
                  res.timer_start = 1'b1;
                  resends++;
               end
            end
            default: ;
         endcase
         res.window_base = oldest_seq;
         expected_q.push_back(res);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(step_result_type got);
         step_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result item with nothing expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
         compare_field("transmit", 8'(want.transmit), 8'(got.transmit));
         compare_field("packet_seq", 8'(want.packet_seq), 8'(got.packet_seq));
         compare_field("packet_slot", 8'(want.packet_slot), 8'(got.packet_slot));
         compare_field("timer_start", 8'(want.timer_start), 8'(got.timer_start));
         compare_field("timer_stop", 8'(want.timer_stop), 8'(got.timer_stop));
         compare_field("window_base", 8'(want.window_base), 8'(got.window_base));
         checked++;
      endfunction
   endclass

   logic          clock;
   logic          reset;
   bit            quiet_tail;
   int            items_sent;
   int            cycle_count;
   window_tracker tracker;

   srsw_req_if req_ch ();
   srsw_rsp_if rsp_ch ();

   selective_repeat_sender_window_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, tracker.expected_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // request monitor: every accepted item feeds the tracker
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         tracker.log_request(req_ch.operation, req_ch.ack_number, req_ch.ack_valid,
                             req_ch.timeout_slot);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_result({rsp_ch.accepted, rsp_ch.transmit, rsp_ch.packet_seq,
                               rsp_ch.packet_slot, rsp_ch.timer_start, rsp_ch.timer_stop,
                               rsp_ch.window_base});
   end

   // response back-pressure: random stalls, none in the quiet tail
   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // present one item at a falling edge, hold it until the block takes it
   task automatic drive_item(input logic [1:0] op, input seq_type ack, input logic ack_ok,
                             input slot_type tslot);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.ack_number   <= ack;
      req_ch.ack_valid    <= ack_ok;
      req_ch.timeout_slot <= tslot;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // mostly well-formed traffic: sends, in-window valid acks, timeouts on used slots
   task automatic random_item();
      int         pick;
      int         in_flight;
      logic [1:0] op;
      seq_type    ack;
      logic       ack_ok;
      slot_type   tslot;
      pick      = $urandom_range(99);
      in_flight = tracker.seq_gap(tracker.oldest_seq, tracker.send_seq);
      ack       = seq_type'($urandom_range(7));
      ack_ok    = 1'($urandom_range(1));
      tslot     = slot_type'($urandom_range(3));
      if (pick < 35) begin
         op = OP_SEND;
      end else if (pick < 75) begin
         op     = OP_ACK;
         ack_ok = ($urandom_range(9) != 0);
         // most acks land on an outstanding number, the rest anywhere
         if (in_flight > 0 && $urandom_range(4) != 0)
            ack = tracker.oldest_seq + seq_type'($urandom_range(in_flight - 1));
      end else if (pick < 90) begin
         op = OP_TIMEOUT;
      end else if (pick < 95) begin
         op = OP_NONE;
      end else begin
         op = 2'($urandom_range(3));
      end
      // never time out a slot that no send has written yet
      if (op == OP_TIMEOUT && !tracker.sent_once[tslot]) begin
         if (tracker.sent_once[tracker.slot_of(tracker.send_seq - 1'b1)])
            tslot = tracker.slot_of(tracker.send_seq - 1'b1);
         else
            op = OP_SEND;
      end
      drive_item(op, ack, ack_ok, tslot);
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      quiet_tail          = 1'b0;
      items_sent          = 0;
      cycle_count         = 0;
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_NONE;
      req_ch.ack_number   = '0;
      req_ch.ack_valid    = 1'b0;
      req_ch.timeout_slot = '0;
      tracker             = new();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unknown operation with every field at its top value
      drive_item(OP_NONE, 3'd7, 1'b1, 2'd3);
      // ack of a number not yet sent marks its slot, the send then clears it
      drive_item(OP_ACK, 3'd0, 1'b1, 2'd0);
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      drive_item(OP_SEND, 3'd7, 1'b1, 2'd3);
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      drive_item(OP_SEND, 3'd7, 1'b1, 2'd3);
      // window full
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      // bad checksum, then an ack a full window ahead
      drive_item(OP_ACK, 3'd0, 1'b0, 2'd0);
      drive_item(OP_ACK, 3'd4, 1'b1, 2'd0);
      // out of order acks, a repeat, then the base slides over three slots
      drive_item(OP_ACK, 3'd1, 1'b1, 2'd0);
      drive_item(OP_ACK, 3'd1, 1'b1, 2'd0);
      drive_item(OP_ACK, 3'd2, 1'b1, 2'd0);
      drive_item(OP_ACK, 3'd0, 1'b1, 2'd0);
      // timeout on an acknowledged slot and on an outstanding one
      drive_item(OP_TIMEOUT, 3'd0, 1'b0, 2'd0);
      drive_item(OP_TIMEOUT, 3'd0, 1'b0, 2'd3);
      // refill across the wrap of the slot index
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      drive_item(OP_SEND, 3'd0, 1'b0, 2'd0);
      // acks newest first, the last one slides the base up to the next number
      drive_item(OP_ACK, 3'd6, 1'b1, 2'd0);
      drive_item(OP_ACK, 3'd5, 1'b1, 2'd0);
      drive_item(OP_ACK, 3'd4, 1'b1, 2'd0);
      drive_item(OP_ACK, 3'd3, 1'b1, 2'd0);
      // empty window: an ack ahead of the next number must not move the base
      drive_item(OP_ACK, 3'd0, 1'b1, 2'd0);
      drive_item(OP_TIMEOUT, 3'd7, 1'b1, 2'd1);
      drive_item(OP_NONE, 3'd0, 1'b0, 2'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_TAIL)
            quiet_tail = 1'b1;
         random_item();
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (tracker.expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request items, %0d results checked, %0d sends refused on a full window",
               items_sent, tracker.checked, tracker.refused);
      $display("%0d acks moved the window base, %0d timeouts resent a packet",
               tracker.slides, tracker.resends);
      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
